[rtl/msbbr_pkg.sv]
// Shared types and constants for the MSB-first bit reader.
package msbbr_pkg;

   localparam int WORD_BITS_DEFAULT = 64;
   localparam int BYTE_BITS         = 8;
   localparam int COUNT_BITS        = 6;
   localparam int VALUE_BITS        = 55;
   localparam int STATUS_BITS       = 2;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic                  func;
      logic [BYTE_BITS-1:0]  data_byte;
      logic [COUNT_BITS-1:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  read_value;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  bits_held;
   } rsp_type;

endpackage

[rtl/msbbr_step.sv]
// Next-state and result logic for one push or read transaction.
module msbbr_step #(
   parameter int WORD_BITS = msbbr_pkg::WORD_BITS_DEFAULT
) (
   input  logic [WORD_BITS-1:0]             acc,
   input  logic [msbbr_pkg::COUNT_BITS-1:0] fill,
   input  msbbr_pkg::req_type               item,
   output logic [WORD_BITS-1:0]             acc_next,
   output logic [msbbr_pkg::COUNT_BITS-1:0] fill_next,
   output msbbr_pkg::rsp_type               result
);

   localparam int            ShBits    = msbbr_pkg::COUNT_BITS + 1;
   localparam logic [ShBits-1:0] WordW = ShBits'(WORD_BITS);
   localparam logic [ShBits-1:0] ByteW = ShBits'(msbbr_pkg::BYTE_BITS);
   localparam logic [ShBits-1:0] MaxRead =
      ShBits'(WORD_BITS - msbbr_pkg::BYTE_BITS - 1);

   logic [ShBits-1:0]    free_bits;
   logic [ShBits-1:0]    push_shamt;
   logic [ShBits-1:0]    read_shamt;
   logic [WORD_BITS-1:0] byte_word;
   logic [WORD_BITS-1:0] value_word;
   logic [msbbr_pkg::VALUE_BITS+WORD_BITS-1:0] value_ext;

   always_comb begin
      free_bits  = WordW - {1'b0, fill};
      push_shamt = free_bits - ByteW;
      read_shamt = WordW - {1'b0, item.bit_count};
      byte_word  = {{(WORD_BITS-msbbr_pkg::BYTE_BITS){1'b0}}, item.data_byte};
      value_word = acc >> read_shamt;
      value_ext  = {{msbbr_pkg::VALUE_BITS{1'b0}}, value_word};

      acc_next          = acc;
      fill_next         = fill;
      result.read_value = '0;
      result.status     = msbbr_pkg::STATUS_OK;

      if (item.func == msbbr_pkg::FUNC_PUSH) begin
         // append the byte just below the held bits, or drop it unless more than a byte of space is free
         if (free_bits > ByteW) begin
            acc_next  = acc | (byte_word << push_shamt);
            fill_next = fill + msbbr_pkg::COUNT_BITS'(msbbr_pkg::BYTE_BITS);
         end else begin
            result.status = msbbr_pkg::STATUS_OVERFLOW;
         end
      end else if (item.bit_count != '0) begin
         if (({1'b0, item.bit_count} > MaxRead) || (item.bit_count > fill)) begin
            result.status = msbbr_pkg::STATUS_UNDERFLOW;
         end else begin
            result.read_value = value_ext[msbbr_pkg::VALUE_BITS-1:0];
            acc_next          = acc << item.bit_count;
            fill_next         = fill - item.bit_count;
         end
      end

      result.bits_held = fill_next;
   end

endmodule

[rtl/msb_first_bit_reader_unit.sv]
// Top level of the MSB-first bit reader: input stage, step logic, result stage.
//
//  channel | ports                          | payload
//  --------+--------------------------------+----------------------------------
//  request | req_valid, req_stall, req_data | func, data_byte, bit_count
//  result  | rsp_valid, rsp_stall, rsp_data | read_value, status, bits_held
//
// One transaction enters per cycle while rsp_stall is low; each request passes
// through the input register, then the result register, before its result is
// presented, so throughput is one transaction per cycle unless the result side
// stalls.
// The accumulator and fill count change when a transaction moves from the input
// register to the result register; a WORD_BITS-wide barrel shift sets the path length.
// Reset (synchronous, active high) empties both stages and clears the state.
// A stall on the result side holds the result register and, only when the
// input register is also full, raises req_stall.
module msb_first_bit_reader_unit #(
   parameter int WORD_BITS = msbbr_pkg::WORD_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  msbbr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output msbbr_pkg::rsp_type rsp_data
);

   // input stage
   logic               in_valid_ff, in_valid_in;
   msbbr_pkg::req_type in_data_ff;

   // result stage
   logic               out_valid_ff, out_valid_in;
   msbbr_pkg::rsp_type out_data_ff;

   // reader state: held bits sit at the top of the accumulator
   logic [WORD_BITS-1:0]             acc_ff, acc_in;
   logic [msbbr_pkg::COUNT_BITS-1:0] fill_ff, fill_in;

   msbbr_pkg::rsp_type step_result;
   logic               advance;
   logic               req_take;

   // move the held transaction forward when the result register is free or
   // is being emptied this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   msbbr_step #(
      .WORD_BITS (WORD_BITS)
   ) u_step (
      .acc       (acc_ff),
      .fill      (fill_ff),
      .item      (in_data_ff),
      .acc_next  (acc_in),
      .fill_next (fill_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         fill_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // commit the state only when the transaction leaves the input stage
         if (advance) begin
            acc_ff  <= acc_in;
            fill_ff <= fill_in;
         end
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/msbbr_checker.sv]
// Port-level checks for the MSB-first bit reader, bound to the top level.
module msbbr_checker #(
   parameter int WORD_BITS = msbbr_pkg::WORD_BITS_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input msbbr_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input msbbr_pkg::rsp_type rsp_data
);

   logic [msbbr_pkg::COUNT_BITS-1:0] last_held_ff;
   logic                             rsp_take;
   logic                             req_seen;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_seen = req_valid && !req_stall && (req_data.func == msbbr_pkg::FUNC_READ
                     || req_data.func == msbbr_pkg::FUNC_PUSH);

   // track the fill count reported by the last delivered result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_held_ff <= '0;
      end else if (rsp_take) begin
         last_held_ff <= rsp_data.bits_held;
      end
   end

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no result appears without an earlier request
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !$past(req_seen)) |=> !rsp_valid)
      else $error("result appeared without a request");

   // an error leaves the fill count as the previous result left it
   a_error_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != msbbr_pkg::STATUS_OK)
      |-> rsp_data.bits_held == last_held_ff)
      else $error("fill count changed on an error result");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind msb_first_bit_reader_unit msbbr_checker #(
   .WORD_BITS (WORD_BITS)
) u_msbbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
